[rtl/phic_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// phic_pkg
// Shared types, constants and the ones' complement adder for the
// pseudo-header Internet checksum unit.
// ============================================================================
package phic_pkg;

    localparam int OFFSET_W = 17;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    // IPv4 header layout
    localparam logic [OFFSET_W-1:0] V4_HDR_LEN    = 17'd20;
    localparam logic [OFFSET_W-1:0] V4_ADDR_START = 17'd12;
    localparam logic [OFFSET_W-1:0] V4_LEN_HI     = 17'd2;
    localparam logic [OFFSET_W-1:0] V4_LEN_LO     = 17'd3;
    localparam logic [OFFSET_W-1:0] V4_PROTO      = 17'd9;

    // IPv6 header layout
    localparam logic [OFFSET_W-1:0] V6_HDR_LEN    = 17'd40;
    localparam logic [OFFSET_W-1:0] V6_ADDR_START = 17'd8;
    localparam logic [OFFSET_W-1:0] V6_LEN_HI     = 17'd4;
    localparam logic [OFFSET_W-1:0] V6_LEN_LO     = 17'd5;
    localparam logic [OFFSET_W-1:0] V6_NEXT_HDR   = 17'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified byte: an optional word for the sum and the end mark
    typedef struct packed {
        logic              add_en;
        logic [WORD_W-1:0] word;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [WORD_W-1:0] ones_add(
        input logic [WORD_W-1:0] acc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W:0] s;
        begin
            s = {1'b0, acc} + {1'b0, word};
            ones_add = s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
        end
    endfunction

endpackage

[rtl/phic_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// phic_front
// Track the byte offset and header fields; turn each byte into a command.
// ============================================================================
module phic_front
    import phic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ip_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  q_status_t         q_status,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic [WORD_W-1:0]   dl_reg, dl_next;

    logic [OFFSET_W-1:0] hdr_start;
    logic [OFFSET_W-1:0] addr_lo;
    logic [OFFSET_W-1:0] pos;
    logic [WORD_W-1:0]   field;
    logic [WORD_W-1:0]   ul_len;
    logic                counted;
    logic                pad_now;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        hdr_start = ip_mode ? V6_HDR_LEN : V4_HDR_LEN;
        addr_lo   = ip_mode ? V6_ADDR_START : V4_ADDR_START;
        pos       = offset_reg - hdr_start;
        field     = {held_reg, in_byte};
        ul_len    = (field >= V4_HDR_LEN[WORD_W-1:0]) ? field - V4_HDR_LEN[WORD_W-1:0]
                                                      : '0;
        held_next = held_reg;
        dl_next   = dl_reg;
        push_cmd  = '{add_en: 1'b0, word: '0, last: in_last};

        // header fields that enter the pseudo-header
        if (!ip_mode)
        begin
            if (offset_reg == V4_LEN_HI)
                held_next = in_byte;
            else if (offset_reg == V4_LEN_LO)
            begin
                dl_next         = ul_len;
                push_cmd.add_en = 1'b1;
                push_cmd.word   = ul_len;
            end
            else if (offset_reg == V4_PROTO)
            begin
                push_cmd.add_en = 1'b1;
                push_cmd.word   = {{BYTE_W{1'b0}}, in_byte};
            end
        end
        else
        begin
            if (offset_reg == V6_LEN_HI)
                held_next = in_byte;
            else if (offset_reg == V6_LEN_LO)
            begin
                dl_next         = field;
                push_cmd.add_en = 1'b1;
                push_cmd.word   = field;
            end
            else if (offset_reg == V6_NEXT_HDR)
            begin
                push_cmd.add_en = 1'b1;
                push_cmd.word   = {{BYTE_W{1'b0}}, in_byte};
            end
        end

        // addresses and upper-layer bytes
        counted = 1'b0;
        pad_now = 1'b0;
        if (offset_reg >= addr_lo && offset_reg < hdr_start)
            counted = 1'b1;
        else if (offset_reg >= hdr_start && offset_reg != OFFSET_MAX
                 && pos < {1'b0, dl_reg})
        begin
            counted = 1'b1;
            pad_now = (pos + 1'b1) == {1'b0, dl_reg};
        end

        if (counted)
        begin
            if (offset_reg[0])
            begin
                push_cmd.add_en = 1'b1;
                push_cmd.word   = field;
            end
            else
            begin
                held_next = in_byte;
                if (in_last || pad_now)
                begin
                    push_cmd.add_en = 1'b1;
                    push_cmd.word   = {in_byte, {BYTE_W{1'b0}}};
                end
            end
        end

        offset_next = (offset_reg == OFFSET_MAX) ? offset_reg : offset_reg + 1'b1;

        if (in_last)
        begin
            offset_next = '0;
            held_next   = '0;
            dl_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            held_reg   <= '0;
            dl_reg     <= '0;
        end
        else if (push)
        begin
            offset_reg <= offset_next;
            held_reg   <= held_next;
            dl_reg     <= dl_next;
        end
    end

endmodule

[rtl/phic_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// phic_queue
// Short command queue between the classifier and the accumulator.
// ============================================================================
module phic_queue
    import phic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign pop_cmd      = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/phic_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// phic_back
// Ones' complement accumulator and output register.
// ============================================================================
module phic_back
    import phic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head,
    input  q_status_t         q_status,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_data
);

    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic              valid_reg;
    logic [WORD_W-1:0] data_reg;

    // hold the head end mark while a result still waits downstream
    assign pop      = !q_status.empty && !(head.last && valid_reg && !out_ready);
    assign sum_next = ones_add(sum_reg, head.add_en ? head.word : '0);

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                sum_reg <= head.last ? '0 : sum_next;
            if (pop && head.last)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
            data_reg <= ~sum_next;
    end

endmodule

[rtl/pseudo_header_internet_checksum_unit.sv]
`timescale 1ns / 1ps
// The last byte's end mark passes through the command queue and the output register to m_tvalid.
// Throughput: one byte per cycle sustained; s_tready drops only when the
//   four-entry command queue fills behind a stalled result.
// Reset: rst_n clears offsets, sum, queue, output valid and ip_mode to zero.
// ============================================================================
// pseudo_header_internet_checksum_unit
// Streaming Internet checksum with IPv4/UDP or IPv6/ICMPv6 pseudo-header.
// ============================================================================
module pseudo_header_internet_checksum_unit
    import phic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: ip_mode (0 = IPv4/UDP, 1 = IPv6/ICMPv6)
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] packet_byte
    input  logic        s_tlast,   // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] checksum
);

    logic      ip_mode_reg;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;
    q_status_t q_status;

    // configuration is always taken; the user must write it only while the block is idle (not enforced here)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ip_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            ip_mode_reg <= cfg_data;
    end

    // front: classify each byte against the header layout of the current mode
    phic_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ip_mode  (ip_mode_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouple the classifier from the accumulator
    phic_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (head),
        .status   (q_status)
    );

    // back: fold words into the sum and emit the complement on the end mark
    phic_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

[rtl/phic_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// phic_checker
// Port-level checks for the checksum unit, bound to the top level.
// ============================================================================
module phic_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_falls_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input ready fell without an accepted word");

    a_reset_clears_output: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind pseudo_header_internet_checksum_unit phic_checker u_phic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/checksum_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// checksum_checker
// Watches the config, byte and checksum channels of the checksum unit.
// Every accepted byte goes through a cycle-free model of the pseudo-header
// sum. A byte marked last queues the expected checksum. Each checksum that
// leaves the unit is compared with the oldest one in the queue.
// ============================================================================
module checksum_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          sums_pending
);

    localparam logic [16:0] V4_HDR_BYTES  = 17'd20;
    localparam logic [16:0] V6_HDR_BYTES  = 17'd40;
    localparam logic [16:0] V4_ADDR_FIRST = 17'd12;
    localparam logic [16:0] V6_ADDR_FIRST = 17'd8;
    localparam logic [16:0] V4_TOTLEN_HI  = 17'd2;
    localparam logic [16:0] V4_TOTLEN_LO  = 17'd3;
    localparam logic [16:0] V4_PROTOCOL   = 17'd9;
    localparam logic [16:0] V6_PAYLEN_HI  = 17'd4;
    localparam logic [16:0] V6_PAYLEN_LO  = 17'd5;
    localparam logic [16:0] V6_NEXTHDR    = 17'd6;
    localparam logic [16:0] OFFSET_CAP    = 17'h1FFFF;

    // Model state for the packet in flight
    bit          v6_sel;
    logic [16:0] byte_pos;
    logic [15:0] acc_sum;
    logic [7:0]  high_byte;
    logic [15:0] ul_length;

    logic [15:0] sums_due[$];
    logic [15:0] want;
    int          mism_count = 0;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        if (s[16])
            return s[15:0] + 16'd1;
        return s[15:0];
    endfunction

    task automatic clear_packet();
        byte_pos  = '0;
        acc_sum   = '0;
        high_byte = '0;
        ul_length = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] exp_sum,
                                   input logic [15:0] got_sum);
        $display("%0t: checksum %s: expected %h, got %h", $realtime, what, exp_sum, got_sum);
        mism_count++;
    endtask

    // Advance the packet model by one byte
    task automatic absorb_byte(input logic [7:0] b, input logic lst);
        logic [16:0] hdr_end;
        logic [16:0] addr_first;
        logic [16:0] p;
        logic [15:0] total;
        bit          counted;
        bit          pad_now;
        hdr_end    = v6_sel ? V6_HDR_BYTES : V4_HDR_BYTES;
        addr_first = v6_sel ? V6_ADDR_FIRST : V4_ADDR_FIRST;
        counted    = 0;
        pad_now    = 0;

        if (!v6_sel) begin
            if (byte_pos == V4_TOTLEN_HI) begin
                high_byte = b;
            end
            else if (byte_pos == V4_TOTLEN_LO) begin
                total     = {high_byte, b};
                ul_length = (total >= 16'd20) ? total - 16'd20 : 16'd0;
                acc_sum   = fold_add(acc_sum, ul_length);
            end
            else if (byte_pos == V4_PROTOCOL) begin
                acc_sum = fold_add(acc_sum, {8'h00, b});
            end
        end
        else begin
            if (byte_pos == V6_PAYLEN_HI) begin
                high_byte = b;
            end
            else if (byte_pos == V6_PAYLEN_LO) begin
                ul_length = {high_byte, b};
                acc_sum   = fold_add(acc_sum, ul_length);
            end
            else if (byte_pos == V6_NEXTHDR) begin
                acc_sum = fold_add(acc_sum, {8'h00, b});
            end
        end

        if (byte_pos >= addr_first && byte_pos < hdr_end) begin
            counted = 1;
        end
        else if (byte_pos >= hdr_end && byte_pos < OFFSET_CAP) begin
            p = byte_pos - hdr_end;
            if (p < {1'b0, ul_length}) begin
                counted = 1;
                pad_now = (p + 17'd1 == {1'b0, ul_length});
            end
        end

        if (counted) begin
            if (byte_pos[0]) begin
                acc_sum = fold_add(acc_sum, {high_byte, b});
            end
            else begin
                high_byte = b;
                // an odd final byte goes in as a high byte over a zero
                if (lst || pad_now)
                    acc_sum = fold_add(acc_sum, {b, 8'h00});
            end
        end

        if (byte_pos != OFFSET_CAP)
            byte_pos = byte_pos + 17'd1;

        if (lst) begin
            sums_due.push_back(~acc_sum);
            clear_packet();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_packet();
            v6_sel = 0;
            sums_due.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (sums_due.size() == 0) begin
                    report_mismatch("with none due", 16'h0000, m_tdata);
                end
                else begin
                    want = sums_due.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("mismatch", want, m_tdata);
                end
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            // a write lands after the byte taken on the same edge
            if (cfg_valid && cfg_ready)
                v6_sel = cfg_data;
        end
        fail_count   <= mism_count;
        sums_pending <= sums_due.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Streams IPv4/UDP and IPv6/ICMPv6 packets, one byte per word, into the
// checksum unit. A directed set of packets comes first, then random packets
// over three back-pressure phases. The checker beside the unit predicts
// and compares every checksum. This module gives the verdict.
// ============================================================================
module tb_top;

    // Mode register codes
    localparam bit MODE_IPV4 = 1'b0;
    localparam bit MODE_IPV6 = 1'b1;

    // Byte fill patterns for generated packets
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int V4_HDR_BYTES = 20;
    localparam int V6_HDR_BYTES = 40;
    localparam int V4_LEN_POS   = 2;    // total length, high byte first
    localparam int V6_LEN_POS   = 4;    // payload length, high byte first

    localparam int SETTLE_CYCLES = 8;    // result path plus queue slack
    localparam int STALL_LIMIT   = 2000; // cycles with no word moving anywhere
    localparam int RANDOM_BYTES  = 760;
    localparam int RANDOM_PKTS   = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] packet_byte
    logic        s_tlast = 1'b0;     // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] checksum

    int          fail_count;
    int          sums_pending;

    int          src_idle_pct = 23;
    int          dst_idle_pct = 54;
    bit          cur_mode = MODE_IPV4;
    logic [7:0]  frame[$];
    int          bytes_sent = 0;
    int          pkts_sent = 0;
    int          stall_cycles = 0;

    pseudo_header_internet_checksum_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    checksum_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .sums_pending(sums_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop m_tready at random to stall the result side
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Watchdog: end the run once nothing has moved for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** pseudo_header_internet_checksum_unit: FAILED **");
                $finish;
            end
        end
    end

    // Offer one byte word; return on the falling edge after it is taken,
    // with s_tvalid still high so back-to-back words stay gapless.
    task automatic send_word(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Fill the frame with a header for the current mode and its length field
    task automatic build_frame(input logic [15:0] len_field, input int n_bytes, input int fill);
        int         len_pos;
        logic [7:0] b;
        len_pos = (cur_mode == MODE_IPV6) ? V6_LEN_POS : V4_LEN_POS;
        frame.delete();
        for (int i = 0; i < n_bytes; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(255));
            endcase
            if (i == len_pos)
                b = len_field[15:8];
            else if (i == len_pos + 1)
                b = len_field[7:0];
            frame.push_back(b);
        end
    endtask

    // Send frame[lo .. hi-1]; mark last on the final byte of the frame
    task automatic send_frame(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_word(frame[i], i == frame.size() - 1);
    endtask

    task automatic send_packet(input logic [15:0] len_field, input int n_bytes, input int fill);
        build_frame(len_field, n_bytes, fill);
        send_frame(0, n_bytes);
    endtask

    // Hold the byte side idle until every checksum is out and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sums_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    // Mostly well-formed packets; the rest are short, truncated or junk
    task automatic random_packet();
        int hdr;
        int kind;
        int ul;
        int lf;
        int n;
        hdr  = (cur_mode == MODE_IPV6) ? V6_HDR_BYTES : V4_HDR_BYTES;
        kind = $urandom_range(99);
        if (kind < 70) begin
            ul = $urandom_range(48);
            if ($urandom_range(9) == 0)
                ul = $urandom_range(300, 49);
            lf = (cur_mode == MODE_IPV6) ? ul : ul + V4_HDR_BYTES;
            n  = hdr + ul;
            if ($urandom_range(3) == 0)
                n += $urandom_range(6, 1);
        end
        else if (kind < 80) begin
            lf = (cur_mode == MODE_IPV6) ? $urandom_range(3) : $urandom_range(19);
            n  = hdr + $urandom_range(8);
        end
        else if (kind < 92) begin
            lf = (cur_mode == MODE_IPV6) ? $urandom_range(60) : $urandom_range(80, 20);
            n  = $urandom_range(hdr, 1);
        end
        else begin
            lf = $urandom_range(65535);
            n  = $urandom_range(hdr + 40, 1);
        end
        send_packet(16'(lf), n, FILL_RANDOM);
        bytes_sent += n;
        pkts_sent++;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed: IPv4 / UDP ----------------
        write_mode(MODE_IPV4);
        send_packet(16'd28, 28, FILL_RANDOM);         // UDP header only
        send_packet(16'd29, 29, FILL_RANDOM);         // odd payload, pad low byte
        send_packet(16'd20, 20, FILL_ZERO);           // empty upper layer, all zero
        send_packet(16'hFFFF, 60, FILL_ONES);         // largest length, ends early
        send_packet(16'd5, 28, FILL_RANDOM);          // total length below header
        send_packet(16'd19, 24, FILL_RANDOM);         // one below the header size
        send_packet(16'd26, 31, FILL_RANDOM);         // excess bytes past length
        send_packet(16'd40, 1, FILL_RANDOM);          // ends on the first byte
        send_packet(16'd40, 3, FILL_RANDOM);          // length field cut in half
        send_packet(16'd40, 4, FILL_RANDOM);          // ends right after length
        send_packet(16'd40, 13, FILL_RANDOM);         // ends on a held address byte

        // ---------------- directed: IPv6 / ICMPv6 ----------------
        write_mode(MODE_IPV6);
        send_packet(16'd8, 48, FILL_RANDOM);
        send_packet(16'd7, 47, FILL_RANDOM);          // odd payload
        send_packet(16'd0, 40, FILL_ZERO);            // empty payload, all zero
        send_packet(16'd6, 52, FILL_ONES);            // excess bytes, all ones
        send_packet(16'd20, 5, FILL_RANDOM);          // length field cut in half
        send_packet(16'd20, 7, FILL_RANDOM);          // ends after next header
        send_packet(16'd4, 40, FILL_RANDOM);          // ends at header boundary
        // longest payload length, packet ends well before it
        send_packet(16'hFFFF, 100, FILL_RANDOM);

        // switch mode inside a packet: v6 header start, v4 rules after
        build_frame(16'd30, 60, FILL_RANDOM);
        send_frame(0, 20);
        write_mode(MODE_IPV4);
        send_frame(20, 60);

        // ---------------- random, three back-pressure phases ----------------
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 23; dst_idle_pct = 54; end
                1: begin src_idle_pct = 54; dst_idle_pct = 23; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            write_mode(ph[0] ? MODE_IPV6 : MODE_IPV4);
            while (bytes_sent < RANDOM_BYTES * (ph + 1) / 3 ||
                   pkts_sent < RANDOM_PKTS * (ph + 1) / 3) begin
                if ($urandom_range(7) == 0)
                    write_mode(1'($urandom_range(1)));
                random_packet();
            end
        end

        // drain the last checksums, then give the verdict
        settle();
        if (fail_count == 0)
            $display("** pseudo_header_internet_checksum_unit: PASSED **");
        else
            $display("** pseudo_header_internet_checksum_unit: FAILED **");
        $finish;
    end

endmodule
